// File: sv/pba_pkg.sv
// Shared types and codes for the paged block allocator.
// Used by paged_block_allocator and pba_out_stage; no dependencies.
package pba_pkg;

    localparam int OPC_W  = 2;
    localparam int SLOT_W = 6;
    localparam int WANT_W = 7;
    localparam int IN_TDW = 16;

    localparam logic [OPC_W-1:0] OP_GET   = 2'd0;
    localparam logic [OPC_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPC_W-1:0] OP_RESET = 2'd2;

    typedef enum logic [1:0] {
        ST_PAGE = 2'd0,
        ST_DONE = 2'd1,
        ST_OOP  = 2'd2
    } t_status;

    typedef struct packed {
        logic    last;
        t_status status;
    } t_out_tag;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_POP,
        S_DRAIN,
        S_STREAM,
        S_FLUSH,
        S_PUSH,
        S_EMIT
    } t_state;

endpackage

// File: sv/pba_out_stage.sv
// Two-entry result queue in front of the master stream port.
// Depends on pba_pkg for the result tag struct.
module pba_out_stage #(
    parameter  int PW  = 12,
    localparam int TDW = ((PW + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [PW-1:0]      i_page,
    input  pba_pkg::t_out_tag  i_tag,
    output logic [1:0]         o_occ,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDW-1:0]     o_m_tdata,   // page_index
    output logic               o_m_tlast,
    output logic [1:0]         o_m_tuser    // status
);
    import pba_pkg::*;

    logic [PW-1:0] r_page [2];
    t_out_tag      r_tag  [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_occ;
    logic          pop;

    assign pop        = o_m_tvalid & i_m_tready;
    assign o_occ      = r_occ;
    assign o_m_tvalid = (r_occ != 2'd0);
    assign o_m_tdata  = TDW'(r_page[r_rd_ptr]);
    assign o_m_tlast  = r_tag[r_rd_ptr].last;
    assign o_m_tuser  = r_tag[r_rd_ptr].status;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_page[r_wr_ptr] <= i_page;
            r_tag[r_wr_ptr]  <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_occ    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_occ <= r_occ + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// File: sv/paged_block_allocator.sv
// Paged block allocator: free-page stack plus per-request page lists.
// Depends on pba_pkg and pba_out_stage.
//
//  channel   | direction | transfer when            | carries
//  ----------+-----------+--------------------------+---------------------------------
//  cfg       | in        | i_cfg_valid & o_cfg_ready| page_count
//  s stream  | in        | i_s_tvalid & o_s_tready  | tuser opcode, tdata slot/wanted
//  m stream  | out       | o_m_tvalid & i_m_tready  | tdata page, tlast, tuser status
//
// One item at a time: a new request is taken only in idle. Page walks run at one page a cycle,
// the read-back only while the result queue has room. A get reads the slot's length, pops any
// missing pages onto the slot's list and streams the list; a free pushes its pages back and
// emits a status, as do all other items. Reset clears control state: the free stack reads as
// identity below a low-water mark and request lengths carry valid bits. A stalled master side
// holds the walk once the two-entry result queue fills.
module paged_block_allocator #(
    parameter  int NUM_PAGES         = 4096,
    parameter  int REQUEST_SLOTS     = 64,
    parameter  int PAGES_PER_REQUEST = 64,
    localparam int PW                = $clog2(NUM_PAGES),
    localparam int CW                = PW + 1,
    localparam int TDW               = ((PW + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CW-1:0]              i_cfg_data,    // page_count
    // request stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [pba_pkg::IN_TDW-1:0] i_s_tdata,     // request_slot[5:0], pages_wanted[12:6]
    input  logic [pba_pkg::OPC_W-1:0]  i_s_tuser,     // opcode
    // result stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [TDW-1:0]             o_m_tdata,     // page_index
    output logic                       o_m_tlast,
    output logic [1:0]                 o_m_tuser      // status
);
    import pba_pkg::*;

    localparam int SW      = $clog2(REQUEST_SLOTS);
    localparam int ENTRIES = REQUEST_SLOTS * PAGES_PER_REQUEST;
    localparam int AW      = $clog2(ENTRIES);
    localparam logic [CW-1:0]     DEPTH_MAX = CW'(NUM_PAGES);
    localparam logic [WANT_W-1:0] PPR       = WANT_W'(PAGES_PER_REQUEST);

    // ---------------------------------------------------------------- memories
    logic [PW-1:0]     r_free_mem  [NUM_PAGES];
    logic [PW-1:0]     r_pages_mem [ENTRIES];
    logic [WANT_W-1:0] r_len_mem   [REQUEST_SLOTS];
    logic [PW-1:0]     r_free_q;
    logic [PW-1:0]     r_pages_q;
    logic [WANT_W-1:0] r_len_q;

    // ---------------------------------------------------------------- registers
    t_state                 r_state, n_state;
    logic [OPC_W-1:0]       r_op, n_op;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [WANT_W-1:0]      r_want, n_want;
    logic [AW-1:0]          r_base, n_base;
    logic [WANT_W-1:0]      r_cnt, n_cnt;
    logic [WANT_W-1:0]      r_end, n_end;
    logic [CW-1:0]          r_depth, n_depth;
    logic [CW-1:0]          r_low, n_low;
    t_status                r_status, n_status;
    logic [CW-1:0]          r_page_count;
    logic [REQUEST_SLOTS-1:0] r_len_vld, n_len_vld;
    logic                   r_rd_inflight, n_rd_inflight;
    logic                   r_q_last, n_q_last;
    // pop pipeline: free-stack read -> page-list write
    logic                   r_pw_vld, n_pw_vld;
    logic [AW-1:0]          r_pw_addr, n_pw_addr;
    logic                   r_pw_ident, n_pw_ident;
    logic [PW-1:0]          r_pw_idx, n_pw_idx;
    // push pipeline: page-list read -> free-stack write
    logic                   r_fw_vld, n_fw_vld;
    logic [PW-1:0]          r_fw_addr, n_fw_addr;
    logic                   r_fw_keep, n_fw_keep;

    // ---------------------------------------------------------------- comb nets
    logic              in_fire;
    logic [SLOT_W-1:0] s_slot;
    logic [WANT_W-1:0] s_want;
    logic [SW-1:0]     slot_idx;
    logic              slot_ok;
    logic [WANT_W-1:0] cur_len;
    logic [CW-1:0]     refill_n;
    logic [1:0]        occ;
    logic              pop;
    logic              room;
    logic              last_step;

    logic              free_re;
    logic [PW-1:0]     free_raddr;
    logic              free_we;
    logic              pages_re;
    logic [AW-1:0]     pages_raddr;
    logic              pages_we;
    logic [PW-1:0]     pages_wdata;
    logic              len_re;
    logic [SW-1:0]     len_raddr;
    logic              len_we;

    logic              emit_valid;
    logic              push_valid;
    logic [PW-1:0]     push_page;
    t_out_tag          push_tag;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_fire     = i_s_tvalid & o_s_tready;
    assign s_slot      = i_s_tdata[SLOT_W-1:0];
    assign s_want      = i_s_tdata[SLOT_W+WANT_W-1:SLOT_W];

    assign slot_idx  = SW'(r_slot);
    assign slot_ok   = (32'(r_slot) < REQUEST_SLOTS);
    assign cur_len   = r_len_vld[slot_idx] ? r_len_q : '0;
    assign refill_n  = (r_page_count > DEPTH_MAX) ? DEPTH_MAX : r_page_count;
    assign last_step = ((r_cnt + WANT_W'(1)) == r_end);

    // Reserve a queue slot for a read in flight; flow stays at one page a cycle while the queue drains.
    assign pop  = o_m_tvalid & i_m_tready;
    assign room = (({1'b0, occ} + {2'b0, r_rd_inflight}) < (3'd2 + {2'b0, pop}));

    // Write sides of the two walk pipelines.
    assign free_we     = r_fw_vld & r_fw_keep;
    assign pages_we    = r_pw_vld;
    // Below the low-water mark the stack still holds its refill pattern.
    assign pages_wdata = r_pw_ident ? r_pw_idx : r_free_q;

    // ---------------------------------------------------------------- memories
    always_ff @(posedge i_clk) begin
        if (free_we) begin
            r_free_mem[r_fw_addr] <= r_pages_q;
        end
        if (free_re) begin
            r_free_q <= r_free_mem[free_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pages_we) begin
            r_pages_mem[r_pw_addr] <= pages_wdata;
        end
        if (pages_re) begin
            r_pages_q <= r_pages_mem[pages_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[slot_idx] <= r_want;
        end
        if (len_re) begin
            r_len_q <= r_len_mem[len_raddr];
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_slot        = r_slot;
        n_want        = r_want;
        n_base        = r_base;
        n_cnt         = r_cnt;
        n_end         = r_end;
        n_depth       = r_depth;
        n_low         = r_low;
        n_status      = r_status;
        n_len_vld     = r_len_vld;
        n_rd_inflight = 1'b0;
        n_q_last      = r_q_last;
        n_pw_vld      = 1'b0;
        n_pw_addr     = r_pw_addr;
        n_pw_ident    = r_pw_ident;
        n_pw_idx      = r_pw_idx;
        n_fw_vld      = 1'b0;
        n_fw_addr     = r_fw_addr;
        n_fw_keep     = r_fw_keep;
        free_re       = 1'b0;
        free_raddr    = PW'(r_depth - CW'(1));
        pages_re      = 1'b0;
        pages_raddr   = r_base + AW'(r_cnt);
        len_re        = 1'b0;
        len_raddr     = SW'(s_slot);
        len_we        = 1'b0;
        emit_valid    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = i_s_tuser;
                    n_slot  = s_slot;
                    n_want  = s_want;
                    n_base  = AW'(32'(s_slot) * PAGES_PER_REQUEST);
                    len_re  = 1'b1;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_state  = S_EMIT;
                n_status = ST_DONE;
                case (r_op)
                    OP_GET: begin
                        if (r_want == '0) begin
                            n_status = ST_DONE;
                        end else if (!slot_ok || (r_want > PPR)) begin
                            n_status = ST_OOP;
                        end else if (cur_len >= r_want) begin
                            n_cnt   = '0;
                            n_end   = r_want;
                            n_state = S_STREAM;
                        end else if (r_depth < CW'(r_want - cur_len)) begin
                            n_status = ST_OOP;
                        end else begin
                            n_cnt               = cur_len;
                            n_end               = r_want;
                            len_we              = 1'b1;
                            n_len_vld[slot_idx] = 1'b1;
                            n_state             = S_POP;
                        end
                    end
                    OP_FREE: begin
                        if (slot_ok) begin
                            n_len_vld[slot_idx] = 1'b0;
                            if (cur_len != '0) begin
                                n_cnt   = '0;
                                n_end   = (cur_len > PPR) ? PPR : cur_len;
                                n_state = S_PUSH;
                            end
                        end
                    end
                    OP_RESET: begin
                        n_depth   = refill_n;
                        n_low     = refill_n;
                        n_len_vld = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                // Pop one page a cycle; its list write lands next cycle.
                free_re    = 1'b1;
                n_pw_vld   = 1'b1;
                n_pw_addr  = r_base + AW'(r_cnt);
                n_pw_ident = (r_depth <= r_low);
                n_pw_idx   = PW'(r_depth - CW'(1));
                n_depth    = r_depth - CW'(1);
                if ((r_depth - CW'(1)) < r_low) begin
                    n_low = r_depth - CW'(1);
                end
                n_cnt = r_cnt + WANT_W'(1);
                if (last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // Let the final list write retire before reading the list back.
                n_cnt   = '0;
                n_state = S_STREAM;
            end
            S_STREAM: begin
                if (room) begin
                    pages_re      = 1'b1;
                    n_rd_inflight = 1'b1;
                    n_q_last      = last_step;
                    n_cnt         = r_cnt + WANT_W'(1);
                    if (last_step) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_rd_inflight) begin
                    n_state = S_IDLE;
                end
            end
            S_PUSH: begin
                // Push pages back in list order; drop any beyond a full stack.
                pages_re  = 1'b1;
                n_fw_vld  = 1'b1;
                n_fw_addr = PW'(r_depth);
                n_fw_keep = (r_depth < DEPTH_MAX);
                if (r_depth < DEPTH_MAX) begin
                    n_depth = r_depth + CW'(1);
                end
                n_cnt = r_cnt + WANT_W'(1);
                if (last_step) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (room) begin
                    emit_valid = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_depth       <= DEPTH_MAX;
            r_low         <= DEPTH_MAX;
            r_len_vld     <= '0;
            r_page_count  <= DEPTH_MAX;
            r_rd_inflight <= 1'b0;
            r_pw_vld      <= 1'b0;
            r_fw_vld      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_depth       <= n_depth;
            r_low         <= n_low;
            r_len_vld     <= n_len_vld;
            r_rd_inflight <= n_rd_inflight;
            r_pw_vld      <= n_pw_vld;
            r_fw_vld      <= n_fw_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_page_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_want     <= n_want;
        r_base     <= n_base;
        r_cnt      <= n_cnt;
        r_end      <= n_end;
        r_status   <= n_status;
        r_q_last   <= n_q_last;
        r_pw_addr  <= n_pw_addr;
        r_pw_ident <= n_pw_ident;
        r_pw_idx   <= n_pw_idx;
        r_fw_addr  <= n_fw_addr;
        r_fw_keep  <= n_fw_keep;
    end

    // ---------------------------------------------------------------- results
    // A page read in flight and a single status result never share a cycle.
    assign push_valid = r_rd_inflight | emit_valid;
    assign push_page  = r_rd_inflight ? r_pages_q : '0;
    always_comb begin
        if (r_rd_inflight) begin
            push_tag.last   = r_q_last;
            push_tag.status = ST_PAGE;
        end else begin
            push_tag.last   = 1'b1;
            push_tag.status = r_status;
        end
    end

    pba_out_stage #(
        .PW (PW)
    ) u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push_valid),
        .i_page     (push_page),
        .i_tag      (push_tag),
        .o_occ      (occ),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // ---------------------------------------------------------------- checks
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("free stack depth beyond capacity");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_depth)
        else $error("low-water mark above stack depth");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_valid |-> (occ != 2'd2 || pop))
        else $error("result queue overflow");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_STREAM || r_state == S_PUSH) |-> (r_cnt < r_end))
        else $error("page walk index past its end");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for paged_block_allocator: directed table plus random traffic.
// Depends on pba_pkg and the allocator RTL; predicts every result in-bench.
module tb_top;
    import pba_pkg::*;

    localparam int NUM_PAGES     = 4096;
    localparam int SLOT_COUNT    = 64;
    localparam int SLOT_CAPACITY = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 150;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_CAP     = 40;
    localparam int PHASE_ITEMS   = 62;

    // opcode 3 is undefined; the block must answer it as a plain done
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [11:0] page;
        logic        last;
        t_status     status;
    } t_result;

    typedef enum logic [1:0] {
        ROW_PREDICT,   // send, results come from the predictor
        ROW_FIXED,     // send, single result typed into the row
        ROW_CFG        // drain, then write page_count
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [OPC_W-1:0]  op;
        logic [SLOT_W-1:0] slot;
        logic [WANT_W-1:0] want;
        logic [12:0]       cfg_val;
        logic [11:0]       page;
        t_status           status;
    } t_vector;

    localparam int N_DIR = 26;

    // Hardware reset leaves page_count at 4096, so page 4095 sits on top.
    t_vector dir_tbl [0:N_DIR-1] = '{
        '{ROW_FIXED,   OP_GET,    6'd0,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_GET,    6'd0,  7'd1,   13'd0,    12'd4095, ST_PAGE},
        '{ROW_PREDICT, OP_GET,    6'd0,  7'd3,   13'd0,    12'd0,    ST_PAGE},
        '{ROW_PREDICT, OP_GET,    6'd0,  7'd2,   13'd0,    12'd0,    ST_PAGE},
        '{ROW_PREDICT, OP_GET,    6'd63, 7'd64,  13'd0,    12'd0,    ST_PAGE},
        '{ROW_FIXED,   OP_GET,    6'd63, 7'd65,  13'd0,    12'd0,    ST_OOP},
        '{ROW_FIXED,   OP_GET,    6'd21, 7'd127, 13'd0,    12'd0,    ST_OOP},
        '{ROW_FIXED,   OP_FREE,   6'd0,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_PREDICT, OP_GET,    6'd42, 7'd5,   13'd0,    12'd0,    ST_PAGE},
        '{ROW_FIXED,   OP_UNUSED, 6'd42, 7'd100, 13'd0,    12'd0,    ST_DONE},
        '{ROW_PREDICT, OP_GET,    6'd42, 7'd5,   13'd0,    12'd0,    ST_PAGE},
        '{ROW_FIXED,   OP_FREE,   6'd63, 7'd127, 13'd0,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_RESET,  6'd63, 7'd127, 13'd0,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_FREE,   6'd7,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_CFG,     OP_GET,    6'd0,  7'd0,   13'd1,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_RESET,  6'd0,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_GET,    6'd1,  7'd2,   13'd0,    12'd0,    ST_OOP},
        '{ROW_FIXED,   OP_GET,    6'd1,  7'd1,   13'd0,    12'd0,    ST_PAGE},
        '{ROW_FIXED,   OP_GET,    6'd2,  7'd1,   13'd0,    12'd0,    ST_OOP},
        '{ROW_CFG,     OP_GET,    6'd0,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_RESET,  6'd0,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_GET,    6'd3,  7'd1,   13'd0,    12'd0,    ST_OOP},
        '{ROW_CFG,     OP_GET,    6'd0,  7'd0,   13'd8191, 12'd0,    ST_DONE},
        '{ROW_FIXED,   OP_RESET,  6'd0,  7'd0,   13'd0,    12'd0,    ST_DONE},
        '{ROW_PREDICT, OP_GET,    6'd3,  7'd64,  13'd0,    12'd0,    ST_PAGE},
        '{ROW_FIXED,   OP_FREE,   6'd3,  7'd0,   13'd0,    12'd0,    ST_DONE}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [12:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [15:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;
    logic [1:0]  o_m_tuser;

    paged_block_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),    // request_slot[5:0], pages_wanted[12:6]
        .i_s_tuser  (i_s_tuser),    // opcode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),    // page_index[11:0]
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)     // status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Allocator shadow: free stack, per-slot page lists, page_count
    // ---------------------------------------------------------------
    logic [11:0] free_stack [NUM_PAGES];
    int          free_depth;
    logic [11:0] slot_pages [SLOT_COUNT][SLOT_CAPACITY];
    int          slot_len   [SLOT_COUNT];
    logic [12:0] page_count_shadow = 13'd4096;
    t_result     result_q [$];
    int          err_count     = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic void restock_pages();
        int n;
        n = (page_count_shadow > NUM_PAGES) ? NUM_PAGES : page_count_shadow;
        for (int i = 0; i < n; i++) free_stack[i] = 12'(i);
        free_depth = n;
        for (int s = 0; s < SLOT_COUNT; s++) slot_len[s] = 0;
    endfunction

    function automatic void push_result(logic [11:0] page, logic last, t_status status);
        result_q.insert(result_q.size(), t_result'{page, last, status});
    endfunction

    // Apply one request to the shadow and queue the results it should produce.
    function automatic void predict_pages(logic [1:0] op, logic [5:0] slot, logic [6:0] want);
        int len;
        int need;
        int cnt;
        len = slot_len[slot];
        if (op == OP_GET) begin
            if (want == 0) begin
                push_result(12'd0, 1'b1, ST_DONE);
                return;
            end
            if (want > SLOT_CAPACITY) begin
                push_result(12'd0, 1'b1, ST_OOP);
                return;
            end
            if (len >= want) begin
                cnt = want;
            end else begin
                need = want - len;
                if (free_depth < need) begin
                    push_result(12'd0, 1'b1, ST_OOP);
                    return;
                end
                // pop from the top, append to the slot's list
                for (int i = 0; i < need; i++) begin
                    free_depth--;
                    slot_pages[slot][len + i] = free_stack[free_depth];
                end
                slot_len[slot] = want;
                cnt = want;
            end
            for (int i = 0; i < cnt; i++)
                push_result(slot_pages[slot][i], (i == cnt - 1), ST_PAGE);
        end else if (op == OP_FREE) begin
            // push back in list order; a full stack drops the page
            for (int i = 0; i < len; i++) begin
                if (free_depth < NUM_PAGES) begin
                    free_stack[free_depth] = slot_pages[slot][i];
                    free_depth++;
                end
            end
            slot_len[slot] = 0;
            push_result(12'd0, 1'b1, ST_DONE);
        end else begin
            if (op == OP_RESET) restock_pages();
            push_result(12'd0, 1'b1, ST_DONE);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        if (err_count < PRINT_CAP)
            $display("%0t ns mismatch %s: got %0d, expected %0d", $time, what, got, want_v);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus side
    // ---------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [5:0] slot,
                             input logic [6:0] want, input bit fixed, input t_result typed);
        int n0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        // hold valid high across back-to-back items; only data changes
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {3'b000, want, slot};
        do @(posedge i_clk); while (!o_s_tready);
        n0 = result_q.size();
        predict_pages(op, slot, want);
        if (fixed) begin
            // shadow state still advances; the typed row replaces its results
            while (result_q.size() > n0) result_q.delete(result_q.size() - 1);
            result_q.insert(result_q.size(), typed);
        end
    endtask

    task automatic wait_drained(input int settle);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_page_count(input logic [12:0] val);
        wait_drained(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        page_count_shadow = val;
    endtask

    // Receiver: stall per cycle at the current rate.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Result checker: compare each transfer with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result head;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result, page", o_m_tdata[11:0], 0);
            end else begin
                head = result_q.pop_front();
                if (o_m_tdata[11:0] !== head.page)
                    report_mismatch("page_index", o_m_tdata[11:0], head.page);
                if (o_m_tlast !== head.last)
                    report_mismatch("tlast", o_m_tlast, head.last);
                if (o_m_tuser !== head.status)
                    report_mismatch("status", o_m_tuser, head.status);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : run
        logic [12:0] phase_pages [3];
        int          send_pct    [3];
        int          recv_pct    [3];
        int          pick;
        logic [1:0]  op;
        logic [5:0]  slot;
        logic [6:0]  want;

        phase_pages = '{13'd200, 13'd24, 13'd4096};
        send_pct    = '{10, 55, 0};
        recv_pct    = '{55, 10, 0};

        restock_pages();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_tbl[r].kind == ROW_CFG)
                write_page_count(dir_tbl[r].cfg_val);
            else
                send_item(dir_tbl[r].op, dir_tbl[r].slot, dir_tbl[r].want,
                          dir_tbl[r].kind == ROW_FIXED,
                          t_result'{dir_tbl[r].page, 1'b1, dir_tbl[r].status});
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            // new page budget only lands through a reset operation
            write_page_count(phase_pages[ph]);
            send_item(OP_RESET, 6'($urandom_range(63)), 7'($urandom_range(127)), 1'b0, '0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                slot = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
                want = ($urandom_range(9) == 0) ? 7'($urandom_range(13, 64))
                                                : 7'($urandom_range(1, 12));
                if (pick < 55) begin
                    op = OP_GET;
                end else if (pick < 78) begin
                    op = OP_FREE;
                    want = 7'($urandom_range(127));
                end else if (pick < 85) begin
                    // zero or oversized requests
                    op = OP_GET;
                    want = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
                end else if (pick < 89) begin
                    op = OP_RESET;
                end else if (pick < 93) begin
                    op = OP_UNUSED;
                    want = 7'($urandom_range(127));
                end else begin
                    // let the pipe run dry before the next get
                    wait_drained(0);
                    op = OP_GET;
                end
                send_item(op, slot, want, 1'b0, '0);
            end
        end

        wait_drained(DRAIN_CYCLES);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
